FILE: rtl/hbt_pkg.sv
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared types and constants of the header block tokenizer.
// ----------------------------------------------------------------------------
package hbt_pkg;

  localparam int LINE_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH       = 4;
  localparam int PTR_BITS          = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  localparam logic [2:0] TK_KEY_BYTE     = 3'd0;
  localparam logic [2:0] TK_KEY_END      = 3'd1;
  localparam logic [2:0] TK_VALUE_BYTE   = 3'd2;
  localparam logic [2:0] TK_HEADER_END   = 3'd3;
  localparam logic [2:0] TK_BLOCK_DONE   = 3'd4;
  localparam logic [2:0] TK_BOGUS        = 3'd5;

  localparam logic REG_START_LINE = 1'b0;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_KEY,
    PH_SKIP,
    PH_VALUE,
    PH_AFTER_NL,
    PH_DONE,
    PH_BOGUS
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [7:0]  data_byte;
    logic [15:0] line_number;
    logic        last_of_step;
  } token_t;

  // Results of one step: first is always present, second only when two is set.
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } step_out_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: rtl/hbt_parse.sv
// ----------------------------------------------------------------------------
// hbt_parse
// Parse state machine and line counter; turns one byte into up to two tokens.
// ----------------------------------------------------------------------------
module hbt_parse #(
  parameter int LINE_BITS = hbt_pkg::LINE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [15:0]        start_line,
  input  logic               advance,
  input  hbt_pkg::item_t     item,
  output logic               emit,
  output hbt_pkg::step_out_t step
);
  import hbt_pkg::*;

  localparam int CMP_W = (LINE_BITS > 16) ? LINE_BITS : 16;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  phase_t               phase, phase_next;
  logic [LINE_BITS-1:0] line_counter, line_counter_next;
  logic [CMP_W-1:0]     start_ext, max_ext, line_ext;
  logic [LINE_BITS-1:0] load_value;
  logic                 eof, nl, blank, bump;
  logic [7:0]           low_byte;
  logic [15:0]          line_out;
  logic [2:0]           kind0, kind1;
  logic [7:0]           data0, data1;
  logic                 n1, n2;

  assign start_ext  = CMP_W'(start_line);
  assign max_ext    = CMP_W'(LINE_MAX);
  assign load_value = (start_ext > max_ext) ? LINE_MAX : start_ext[LINE_BITS-1:0];

  assign eof      = item.end_of_file;
  assign nl       = !eof && item.byte_in == CH_NEWLINE;
  assign blank    = !eof && (item.byte_in == CH_SPACE || item.byte_in == CH_TAB);
  assign low_byte = to_lower(item.byte_in);

  always_comb begin
    phase_next = phase;
    bump  = 1'b0;
    n1    = 1'b0;
    n2    = 1'b0;
    kind0 = TK_KEY_BYTE;
    data0 = 8'd0;
    kind1 = TK_BLOCK_DONE;
    data1 = 8'd0;
    unique case (phase)
      PH_LINE_START: begin
        n1 = 1'b1;
        if (eof || nl) begin
          bump       = nl;
          kind0      = TK_BLOCK_DONE;
          phase_next = PH_DONE;
        end else begin
          kind0      = TK_KEY_BYTE;
          data0      = low_byte;
          phase_next = PH_KEY;
        end
      end
      PH_KEY: begin
        n1 = 1'b1;
        if (eof || nl) begin
          kind0      = TK_BOGUS;
          phase_next = PH_BOGUS;
        end else if (item.byte_in == CH_COLON) begin
          kind0      = TK_KEY_END;
          phase_next = PH_SKIP;
        end else begin
          kind0 = TK_KEY_BYTE;
          data0 = low_byte;
        end
      end
      PH_SKIP, PH_VALUE: begin
        if (eof) begin
          n2         = 1'b1;
          kind0      = TK_HEADER_END;
          kind1      = TK_BLOCK_DONE;
          phase_next = PH_DONE;
        end else if (nl) begin
          bump       = 1'b1;
          phase_next = PH_AFTER_NL;
        end else if (!(blank && phase == PH_SKIP)) begin
          n1         = 1'b1;
          kind0      = TK_VALUE_BYTE;
          data0      = item.byte_in;
          phase_next = PH_VALUE;
        end
      end
      PH_AFTER_NL: begin
        if (blank) begin
          // A folded line: the newline becomes part of the value.
          n1         = 1'b1;
          kind0      = TK_VALUE_BYTE;
          data0      = CH_NEWLINE;
          phase_next = PH_SKIP;
        end else if (eof || nl) begin
          bump       = nl;
          n2         = 1'b1;
          kind0      = TK_HEADER_END;
          kind1      = TK_BLOCK_DONE;
          phase_next = PH_DONE;
        end else begin
          n2         = 1'b1;
          kind0      = TK_HEADER_END;
          kind1      = TK_KEY_BYTE;
          data1      = low_byte;
          phase_next = PH_KEY;
        end
      end
      default: begin
        // Done or bogus: everything is dropped until reset.
      end
    endcase
  end

  assign line_counter_next = (bump && line_counter != LINE_MAX) ?
                             line_counter + 1'b1 : line_counter;
  assign line_ext          = CMP_W'(line_counter_next);
  assign line_out          = line_ext[15:0];

  assign emit = n1 || n2;
  always_comb begin
    step.two                 = n2;
    step.first.token_kind    = kind0;
    step.first.data_byte     = data0;
    step.first.line_number   = line_out;
    step.first.last_of_step  = !n2;
    step.second.token_kind   = kind1;
    step.second.data_byte    = data1;
    step.second.line_number  = line_out;
    step.second.last_of_step = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LINE_START;
      line_counter <= LINE_BITS'(1);
    end else if (load) begin
      line_counter <= load_value;
    end else if (advance) begin
      phase        <= phase_next;
      line_counter <= line_counter_next;
    end
  end

endmodule

FILE: rtl/hbt_queue.sv
// ----------------------------------------------------------------------------
// hbt_queue
// Small queue of steps; hands out one token per cycle while not stalled, two for a double step.
// ----------------------------------------------------------------------------
module hbt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hbt_pkg::step_out_t push_step,
  output logic               has_room,
  output logic               token_valid,
  input  logic               token_stall,
  output hbt_pkg::token_t    token
);
  import hbt_pkg::*;

  step_out_t           entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [PTR_BITS:0]   count;
  logic                half;
  logic                take, pop;
  step_out_t           head;

  assign head        = entries[rd_ptr];
  assign has_room    = count != (PTR_BITS + 1)'(QUEUE_DEPTH);
  assign token_valid = count != '0;
  assign token       = half ? head.second : head.first;
  assign take        = token_valid && !token_stall;
  // The entry leaves once its last token has been taken.
  assign pop         = take && (half || !head.two);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      half   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
        half   <= 1'b0;
      end else if (take) begin
        half <= 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/header_block_tokenizer.sv
// ----------------------------------------------------------------------------
// header_block_tokenizer
// Header block tokenizer with line folding, APB register port on top.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the queue has room. It is parsed
// straight out of an input register, and its tokens enter a four-step queue
// as soon as the queue has room. The queue hands out one token per cycle
// while token_stall is low, so a byte that yields two tokens hands them out
// in turn, and the input stalls only when the queue is full. Register
// start_line sits at byte address 0; the user must write it only while the
// block is idle, which the block itself does not enforce.
module header_block_tokenizer #(
  parameter int LINE_BITS = hbt_pkg::LINE_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  hbt_pkg::item_t  item,
  output logic            token_valid,
  input  logic            token_stall,
  output hbt_pkg::token_t token,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import hbt_pkg::*;

  item_t     held;
  logic      held_valid;
  logic      has_room;
  logic      advance;
  logic      emit;
  logic      load;
  logic      reg_sel;
  logic [15:0] start_line;
  step_out_t step;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign load    = psel && penable && pwrite && pready && reg_sel == REG_START_LINE;
  assign prdata  = (reg_sel == REG_START_LINE) ? {16'd0, start_line} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_line <= 16'd1;
    end else if (load) begin
      start_line <= pwdata[15:0];
    end
  end

  assign advance    = held_valid && has_room;
  assign item_stall = held_valid && !has_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  hbt_parse #(
    .LINE_BITS(LINE_BITS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .start_line (pwdata[15:0]),
    .advance    (advance),
    .item       (held),
    .emit       (emit),
    .step       (step)
  );

  hbt_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (advance && emit),
    .push_step   (step),
    .has_room    (has_room),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

endmodule

FILE: sim/header_block_tokenizer_test.sv
// ----------------------------------------------------------------------------
// header_block_tokenizer_test
// Self-checking testbench for the header block tokenizer. A queue of bytes
// forms one long header block: a short directed opening, then batches of
// random header lines with folded continuations, then one randomly chosen
// way of closing the block and a few bytes that must be ignored. start_line
// is rewritten between batches, including its extremes. Each accepted byte
// is run through a local tokenizer model, and every token that leaves the
// block is compared field by field with the oldest predicted token.
// ----------------------------------------------------------------------------
module header_block_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hbt_pkg::*;

  localparam logic [2:0] START_LINE_ADDR = {REG_START_LINE, 2'b00};

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item_in = '0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  token_t      token;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the tokenizer state and its register.
  phase_t      parse_state = PH_LINE_START;
  logic [15:0] line_counter = 16'd1;
  logic [15:0] start_line_cfg = 16'd1;

  token_t      expected_tokens [$];
  item_t       byte_feed [$];
  int unsigned bytes_queued = 0;
  int unsigned send_wait = 0;
  int unsigned stall_wait = 0;
  bit          steady_mode = 1'b0;
  int          error_count = 0;

  header_block_tokenizer u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item_in),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("header_block_tokenizer_test: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  // Mostly short gaps, now and then a long one; none at all in steady mode.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_mode || r < 55) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b | 8'h20 : b;
  endfunction

  function automatic token_t make_token(input logic [2:0] kind, input logic [7:0] data);
    token_t t;
    t = '0;
    t.token_kind = kind;
    t.data_byte  = data;
    return t;
  endfunction

  task automatic count_line();
    if (line_counter != 16'hFFFF) begin
      line_counter = line_counter + 16'd1;
    end
  endtask

  // Works out the tokens that one accepted transaction produces.
  task automatic tokenize_byte(input item_t it);
    token_t      step_tokens [$];
    token_t      t;
    logic [7:0]  b;
    logic        eof;
    logic        nl;
    logic        blank;
    b     = it.byte_in;
    eof   = it.end_of_file;
    nl    = !eof && b == CH_NEWLINE;
    blank = !eof && (b == CH_SPACE || b == CH_TAB);
    case (parse_state)
      PH_LINE_START: begin
        if (eof || nl) begin
          if (nl) begin
            count_line();
          end
          step_tokens.push_back(make_token(TK_BLOCK_DONE, 8'h00));
          parse_state = PH_DONE;
        end else begin
          step_tokens.push_back(make_token(TK_KEY_BYTE, fold_case(b)));
          parse_state = PH_KEY;
        end
      end
      PH_KEY: begin
        // A key cut short leaves the line count alone.
        if (eof || nl) begin
          step_tokens.push_back(make_token(TK_BOGUS, 8'h00));
          parse_state = PH_BOGUS;
        end else if (b == CH_COLON) begin
          step_tokens.push_back(make_token(TK_KEY_END, 8'h00));
          parse_state = PH_SKIP;
        end else begin
          step_tokens.push_back(make_token(TK_KEY_BYTE, fold_case(b)));
        end
      end
      PH_SKIP, PH_VALUE: begin
        if (eof) begin
          step_tokens.push_back(make_token(TK_HEADER_END, 8'h00));
          step_tokens.push_back(make_token(TK_BLOCK_DONE, 8'h00));
          parse_state = PH_DONE;
        end else if (nl) begin
          count_line();
          parse_state = PH_AFTER_NL;
        end else if (!(blank && parse_state == PH_SKIP)) begin
          step_tokens.push_back(make_token(TK_VALUE_BYTE, b));
          parse_state = PH_VALUE;
        end
      end
      PH_AFTER_NL: begin
        if (blank) begin
          step_tokens.push_back(make_token(TK_VALUE_BYTE, CH_NEWLINE));
          parse_state = PH_SKIP;
        end else if (eof || nl) begin
          if (nl) begin
            count_line();
          end
          step_tokens.push_back(make_token(TK_HEADER_END, 8'h00));
          step_tokens.push_back(make_token(TK_BLOCK_DONE, 8'h00));
          parse_state = PH_DONE;
        end else begin
          step_tokens.push_back(make_token(TK_HEADER_END, 8'h00));
          step_tokens.push_back(make_token(TK_KEY_BYTE, fold_case(b)));
          parse_state = PH_KEY;
        end
      end
      default: begin
      end
    endcase
    foreach (step_tokens[k]) begin
      t = step_tokens[k];
      t.line_number  = line_counter;
      t.last_of_step = (k == step_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endtask

  task automatic check_token(input token_t got);
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected token kind %0d data %02h line %0d",
                                got.token_kind, got.data_byte, got.line_number));
    end else begin
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind) begin
        report_mismatch($sformatf("token_kind %0d, want %0d", got.token_kind, want.token_kind));
      end
      if (got.data_byte !== want.data_byte) begin
        report_mismatch($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
      end
      if (got.line_number !== want.line_number) begin
        report_mismatch($sformatf("line_number %0d, want %0d",
                                  got.line_number, want.line_number));
      end
      if (got.last_of_step !== want.last_of_step) begin
        report_mismatch($sformatf("last_of_step %0b, want %0b",
                                  got.last_of_step, want.last_of_step));
      end
    end
  endtask

  // Byte driver: the payload is held while the block stalls.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_wait  <= 0;
    end else if (!(item_valid && item_stall)) begin
      if (send_wait != 0) begin
        item_valid <= 1'b0;
        send_wait  <= send_wait - 1;
      end else if (byte_feed.size() != 0) begin
        item_in    <= byte_feed.pop_front();
        item_valid <= 1'b1;
        send_wait  <= pick_idle();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      token_stall <= 1'b0;
      stall_wait  <= 0;
    end else if (stall_wait != 0) begin
      token_stall <= 1'b1;
      stall_wait  <= stall_wait - 1;
    end else begin
      token_stall <= 1'b0;
      stall_wait  <= pick_idle();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (token_valid && !token_stall) begin
        check_token(token);
      end
      if (item_valid && !item_stall) begin
        tokenize_byte(item_in);
      end
    end
  end

  task automatic check_start_line();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= START_LINE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready !== 1'b1) begin
      report_mismatch("pready low during a read");
    end
    if (prdata !== {16'h0000, start_line_cfg}) begin
      report_mismatch($sformatf("start_line reads %08h, want %04h", prdata, start_line_cfg));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The write also reloads the line counter at once.
  task automatic write_start_line(input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_LINE_ADDR;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    start_line_cfg = value;
    line_counter   = value;
    check_start_line();
  endtask

  // Waits until the byte queue is drained and every predicted token is out,
  // then leaves room for a trailing newline that produces no token.
  task automatic wait_idle();
    while (byte_feed.size() != 0 || item_valid || expected_tokens.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    item_t it;
    it.byte_in     = b;
    it.end_of_file = 1'b0;
    byte_feed.push_back(it);
    bytes_queued++;
  endtask

  task automatic push_eof();
    item_t it;
    it.byte_in     = 8'($urandom);
    it.end_of_file = 1'b1;
    byte_feed.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic [7:0] rand_text(input bit no_colon, input bit no_blank);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 3) == 0) begin
        b = 8'($urandom_range(8'h41, 8'h5A));
      end else begin
        b = 8'($urandom_range(0, 255));
      end
    end while (b == CH_NEWLINE || (no_colon && b == CH_COLON) ||
               (no_blank && (b == CH_SPACE || b == CH_TAB)));
    return b;
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
  endfunction

  task automatic push_key();
    int unsigned n;
    n = $urandom_range(0, 6);
    // A leading colon is still a key byte.
    push_byte($urandom_range(0, 9) == 0 ? CH_COLON : rand_text(1'b1, 1'b1));
    repeat (n) push_byte(rand_text(1'b1, 1'b0));
  endtask

  task automatic push_header_line();
    int unsigned n;
    push_key();
    push_byte(CH_COLON);
    n = $urandom_range(0, 3);
    repeat (n) push_byte(rand_blank());
    n = $urandom_range(0, 10);
    repeat (n) push_byte(rand_text(1'b0, 1'b0));
    push_byte(CH_NEWLINE);
    while ($urandom_range(0, 9) < 3) begin
      n = $urandom_range(1, 3);
      repeat (n) push_byte(rand_blank());
      n = $urandom_range(0, 8);
      repeat (n) push_byte(rand_text(1'b0, 1'b0));
      push_byte(CH_NEWLINE);
    end
  endtask

  task automatic fill_headers(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) begin
      push_header_line();
    end
  endtask

  // The block locks once it is closed, so only one way of closing is tried
  // per run; the bytes after it must produce nothing.
  task automatic push_closing();
    int unsigned n;
    case ($urandom_range(0, 5))
      0: push_byte(CH_NEWLINE);
      1: push_eof();
      2: begin
        push_key();
        push_byte(CH_COLON);
        n = $urandom_range(1, 4);
        repeat (n) push_byte(rand_text(1'b0, 1'b1));
        push_eof();
      end
      3: begin
        push_key();
        push_byte(CH_COLON);
        push_eof();
      end
      4: begin
        push_key();
        push_byte(CH_NEWLINE);
      end
      default: begin
        push_key();
        push_eof();
      end
    endcase
    repeat (6) begin
      if ($urandom_range(0, 1)) begin
        push_eof();
      end else begin
        push_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] opening [];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    check_start_line();

    opening = '{CH_COLON, 8'h41, 8'h5A, 8'h40, 8'h5B, 8'h61, 8'h7A, CH_COLON,
                CH_SPACE, CH_TAB, 8'h00, 8'hFF, CH_SPACE, 8'h51, CH_NEWLINE,
                CH_SPACE, CH_TAB, 8'h7F, CH_NEWLINE, 8'h4B, CH_COLON, CH_NEWLINE,
                CH_TAB, CH_NEWLINE, 8'h6D, CH_COLON, 8'h76, CH_NEWLINE};
    foreach (opening[i]) begin
      push_byte(opening[i]);
    end
    wait_idle();

    write_start_line(16'h0000);
    fill_headers(250);
    wait_idle();

    write_start_line(16'hFFFF);
    fill_headers(250);
    wait_idle();

    write_start_line(16'($urandom));
    steady_mode = 1'b1;
    fill_headers(250);
    wait_idle();
    steady_mode = 1'b0;

    // Close enough to the top that the counter saturates during the batch.
    write_start_line(16'hFFFA);
    fill_headers(250);
    wait_idle();

    push_closing();
    wait_idle();
    repeat (12) @(posedge clk);

    if (expected_tokens.size() != 0) begin
      report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
    end
    if (error_count == 0) begin
      $display("header_block_tokenizer_test: PASS");
    end else begin
      $display("header_block_tokenizer_test: FAIL");
    end
    $finish;
  end

endmodule
